@@ rtl/core/fraction_reduce_unit_defines.svh @@
// ----------------------------------------------------------------------------
// fraction_reduce_unit_defines.svh
// Assertion macros used by the fraction reduce unit sequencer (fru_ctrl).
// ----------------------------------------------------------------------------
`ifndef FRACTION_REDUCE_UNIT_DEFINES_SVH
`define FRACTION_REDUCE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FRU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fraction_reduce_unit: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fraction_reduce_unit: next-cycle check failed");

`endif

@@ rtl/core/fru_pkg.sv @@
// ----------------------------------------------------------------------------
// fru_pkg
// Types and constants shared by the fraction reduce unit modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fru_pkg;

    // Width of each signed fraction field on the streams.
    localparam int FIELD_W = 32;
    // Two fields packed per item.
    localparam int TDATA_W = 2 * FIELD_W;
    // Widest supported magnitude; used to extend values before slicing.
    localparam int EXT_W   = 64;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_GCD  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic special;
        logic gcd_done;
        logic div_last;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ rtl/core/fru_ctrl.sv @@
// ----------------------------------------------------------------------------
// fru_ctrl
// Sequencer: load, binary GCD, parallel division, hand-off to output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fraction_reduce_unit_defines.svh"

module fru_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output fru_pkg::t_dp_cmd  o_cmd,
    input  fru_pkg::t_dp_stat i_stat
);

    fru_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            in_accept;
    logic            out_free;
    logic            div_end;

    assign o_in_ready  = (r_state == fru_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign div_end     = (r_state == fru_pkg::S_DIV) && i_stat.div_last;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            fru_pkg::S_IDLE: begin
                if (in_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = fru_pkg::S_GCD;
                end
            end
            fru_pkg::S_GCD: begin
                if (i_stat.special) begin
                    n_state = fru_pkg::S_DONE;
                end else if (i_stat.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = fru_pkg::S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            fru_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = fru_pkg::S_DONE;
                end
            end
            fru_pkg::S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = fru_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fru_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fru_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `FRU_ASSERT_NEXT(a_accept_starts_gcd, i_clk, i_rst_n, in_accept, r_state == fru_pkg::S_GCD)
    `FRU_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load, !r_out_valid || i_out_ready)
    `FRU_ASSERT_NEXT(a_div_ends, i_clk, i_rst_n, div_end, r_state == fru_pkg::S_DONE)

endmodule

`default_nettype wire

@@ rtl/core/fru_datapath.sv @@
// ----------------------------------------------------------------------------
// fru_datapath
// Magnitude/sign split, binary GCD, two restoring dividers, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fru_datapath #(
    parameter int WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire [fru_pkg::TDATA_W-1:0]   i_in_data,
    input  fru_pkg::t_dp_cmd             i_cmd,
    output fru_pkg::t_dp_stat            o_stat,
    output logic [fru_pkg::FIELD_W-1:0]  o_num,
    output logic [fru_pkg::FIELD_W-1:0]  o_den,
    output logic                         o_flag
);

    localparam int KW = $clog2(WIDTH);
    localparam int CW = $clog2(WIDTH + 1);

    // Input split
    logic [fru_pkg::FIELD_W-1:0] in_num, in_den, abs_num, abs_den;
    logic [fru_pkg::EXT_W-1:0]   ext_num, ext_den;
    logic [WIDTH-1:0]            mag_num, mag_den;

    assign in_num  = i_in_data[fru_pkg::FIELD_W-1:0];
    assign in_den  = i_in_data[fru_pkg::TDATA_W-1:fru_pkg::FIELD_W];
    assign abs_num = in_num[fru_pkg::FIELD_W-1] ? (fru_pkg::FIELD_W'(0) - in_num) : in_num;
    assign abs_den = in_den[fru_pkg::FIELD_W-1] ? (fru_pkg::FIELD_W'(0) - in_den) : in_den;
    assign ext_num = fru_pkg::EXT_W'(abs_num);
    assign ext_den = fru_pkg::EXT_W'(abs_den);
    assign mag_num = ext_num[WIDTH-1:0];
    assign mag_den = ext_den[WIDTH-1:0];

    logic [fru_pkg::FIELD_W-1:0] r_raw_num, r_raw_den;
    logic                        r_zero_num, r_zero_den;
    logic [WIDTH-1:0]            r_a, r_b, r_g, r_qn, r_qd, r_rn, r_rd;
    logic [KW-1:0]               r_k;
    logic [CW-1:0]               r_cnt;

    // GCD step
    logic [WIDTH-1:0] n_a, n_b;
    logic [KW-1:0]    n_k;

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_k = r_k;
        if (!r_a[0] && !r_b[0]) begin
            n_a = r_a >> 1;
            n_b = r_b >> 1;
            n_k = r_k + KW'(1);
        end else if (!r_a[0]) begin
            n_a = r_a >> 1;
        end else if (!r_b[0]) begin
            n_b = r_b >> 1;
        end else if (r_a > r_b) begin
            n_a = (r_a - r_b) >> 1;
        end else begin
            n_b = (r_b - r_a) >> 1;
        end
    end

    // Division step, both dividers share the divisor
    logic [WIDTH:0]   trial_n, trial_d, diff_n, diff_d;
    logic             ge_n, ge_d;

    assign trial_n = {r_rn, r_qn[WIDTH-1]};
    assign trial_d = {r_rd, r_qd[WIDTH-1]};
    assign diff_n  = trial_n - {1'b0, r_g};
    assign diff_d  = trial_d - {1'b0, r_g};
    assign ge_n    = trial_n >= {1'b0, r_g};
    assign ge_d    = trial_d >= {1'b0, r_g};

    assign o_stat.special  = r_zero_num || r_zero_den;
    assign o_stat.gcd_done = (r_a == r_b);
    assign o_stat.div_last = (r_cnt == CW'(1));

    // Result
    logic [fru_pkg::EXT_W-1:0]   ext_qn, ext_qd;
    logic [fru_pkg::FIELD_W-1:0] q_num, q_den, res_num, res_den;

    assign ext_qn = fru_pkg::EXT_W'(r_qn);
    assign ext_qd = fru_pkg::EXT_W'(r_qd);
    assign q_num  = ext_qn[fru_pkg::FIELD_W-1:0];
    assign q_den  = ext_qd[fru_pkg::FIELD_W-1:0];

    always_comb begin
        if (r_zero_den) begin
            res_num = r_raw_num;
            res_den = r_raw_den;
        end else if (r_zero_num) begin
            res_num = '0;
            res_den = r_raw_den[fru_pkg::FIELD_W-1] ? '1 : fru_pkg::FIELD_W'(1);
        end else begin
            res_num = r_raw_num[fru_pkg::FIELD_W-1] ? (fru_pkg::FIELD_W'(0) - q_num) : q_num;
            res_den = r_raw_den[fru_pkg::FIELD_W-1] ? (fru_pkg::FIELD_W'(0) - q_den) : q_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw_num  <= in_num;
            r_raw_den  <= in_den;
            r_zero_num <= (mag_num == '0);
            r_zero_den <= (mag_den == '0);
            r_a        <= mag_num;
            r_b        <= mag_den;
            r_qn       <= mag_num;
            r_qd       <= mag_den;
            r_k        <= '0;
        end
        if (i_cmd.gcd_step) begin
            r_a <= n_a;
            r_b <= n_b;
            r_k <= n_k;
        end
        if (i_cmd.div_init) begin
            r_g   <= r_a << r_k;
            r_rn  <= '0;
            r_rd  <= '0;
            r_cnt <= CW'(WIDTH);
        end
        if (i_cmd.div_step) begin
            r_rn  <= ge_n ? diff_n[WIDTH-1:0] : trial_n[WIDTH-1:0];
            r_rd  <= ge_d ? diff_d[WIDTH-1:0] : trial_d[WIDTH-1:0];
            r_qn  <= {r_qn[WIDTH-2:0], ge_n};
            r_qd  <= {r_qd[WIDTH-2:0], ge_d};
            r_cnt <= r_cnt - CW'(1);
        end
        if (i_cmd.out_load) begin
            o_num  <= res_num;
            o_den  <= res_den;
            o_flag <= r_zero_den;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/fraction_reduce_unit.sv @@
// ----------------------------------------------------------------------------
// fraction_reduce_unit
// Reduces a signed fraction to lowest terms through a full GCD.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries one fraction per item: tdata[31:0] is the
//   signed numerator, tdata[63:32] the signed denominator. Master stream
//   m_axis returns one item per input: tdata[31:0] reduced numerator,
//   tdata[63:32] reduced denominator, tuser set when the denominator
//   magnitude is zero (pair passed through unchanged).
//   Each output keeps the sign of its own input. A zero numerator gives
//   a denominator of +1 or -1. Magnitudes are taken as WIDTH-bit unsigned.
// Timing:
//   One item at a time. Per item: an accept step, G binary GCD steps
//   (one shift or subtract-and-shift per cycle, G at most 2*WIDTH-2),
//   a divisor setup step, WIDTH restoring-division steps for both
//   quotients in parallel, and a hand-off to the output register. A
//   zero operand skips the GCD and division steps. The GCD loop and the
//   bit-serial dividers set the time taken per item.
// Reset and stall:
//   Synchronous active-low reset returns the sequencer to idle and drops
//   m_axis_tvalid. The output register lets the next item be taken while
//   a result waits; a stalled master holds its result and the sequencer
//   waits at the hand-off until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_reduce_unit #(
    parameter int WIDTH = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // numerator_in [31:0], denominator_in [63:32]
    input  wire  [fru_pkg::TDATA_W-1:0]        s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // numerator_out [31:0], denominator_out [63:32]
    output logic [fru_pkg::TDATA_W-1:0]        m_axis_tdata,
    // undefined_flag [0]
    output logic                               m_axis_tuser
);

    fru_pkg::t_dp_cmd  cmd;
    fru_pkg::t_dp_stat stat;
    logic [fru_pkg::FIELD_W-1:0] res_num, res_den;

    // Sequencer: owns the handshakes and the output valid flag.
    fru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Arithmetic and the output payload register.
    fru_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_in_data (s_axis_tdata),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_num     (res_num),
        .o_den     (res_den),
        .o_flag    (m_axis_tuser)
    );

    // Pack denominator above numerator.
    assign m_axis_tdata = {res_den, res_num};

endmodule

`default_nettype wire
